// ----- hw/rtl/modular_alu_96bit_top_assert.svh -----
// Assertion macros for the modular ALU top level.
// Needs clk and arst_n in scope where the macros are used.
`ifndef MODULAR_ALU_96BIT_TOP_ASSERT_SVH
`define MODULAR_ALU_96BIT_TOP_ASSERT_SVH

// same-cycle implication
`define MALU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MALU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/malu_pkg.sv -----
// Shared types and constants of the modular ALU.
// No dependencies; compiled before every other file.
package malu_pkg;

	localparam int OPERAND_BITS_DEF = 96;
	// staging width for field/operand width conversion
	localparam int FIELD_BITS       = 128;
	localparam int CMD_BITS         = 2;
	localparam int LOW_BITS         = 64;
	localparam int HIGH_BITS        = 32;
	localparam int PRIME_HIGH_BITS  = 31;
	localparam int CFG_IDX_BITS     = 2;
	localparam int CFG_DATA_BITS    = 64;
	localparam int RES_BITS         = LOW_BITS + HIGH_BITS;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME_LOW  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME_HIGH = CFG_IDX_BITS'(1);

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_POW = 2'd3
	} cmd_t;

	// datapath operations, one per cycle
	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_ADD_AB,
		DP_RED_CARRY,
		DP_SUB_AB,
		DP_FIX_BORROW,
		DP_MUL_DBL,
		DP_MUL_ADD,
		DP_MUL_RED,
		DP_MUL_INIT_SQ,
		DP_MUL_INIT_ACC,
		DP_SQ_FROM_C,
		DP_SQ_FROM_C_SHR,
		DP_ACC_FROM_SQ_SHR,
		DP_ACC_FROM_C,
		DP_E_SHR,
		DP_ONE,
		DP_C_FROM_ACC
	} dp_op_t;

	typedef struct packed {
		logic mul_bit;   // current multiplier bit
		logic cnt_zero;  // last bit-step of a multiply
		logic e_zero;    // exponent exhausted
		logic e_lsb;     // exponent bit 0
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_SUM,
		ST_ADD_RED,
		ST_SUB_DIF,
		ST_SUB_FIX,
		ST_MUL_DBL,
		ST_MUL_ADD,
		ST_MUL_RED,
		ST_PW_START,
		ST_PW_SQ1_END,
		ST_PW_LOOP,
		ST_PW_SQ2_END,
		ST_PW_ACC_INIT,
		ST_PW_ACC_END,
		ST_PW_SHIFT,
		ST_DONE
	} state_t;

	// where a multiply returns to
	typedef enum logic [1:0] {
		RET_DONE,
		RET_SQ1,
		RET_SQ2,
		RET_ACC
	} ret_t;

endpackage

// ----- hw/rtl/malu_if.sv -----
// Valid/ready channel interfaces of the modular ALU: request, response, config.
// Depends on malu_pkg for field widths.
interface malu_req_if;
	import malu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_BITS-1:0]  cmd;
	logic [LOW_BITS-1:0]  a_low;
	logic [HIGH_BITS-1:0] a_high;
	logic [LOW_BITS-1:0]  b_low;
	logic [HIGH_BITS-1:0] b_high;

	modport source (output valid, cmd, a_low, a_high, b_low, b_high, input ready);
	modport sink (input valid, cmd, a_low, a_high, b_low, b_high, output ready);
endinterface

interface malu_rsp_if;
	import malu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [LOW_BITS-1:0]  r_low;
	logic [HIGH_BITS-1:0] r_high;

	modport source (output valid, r_low, r_high, input ready);
	modport sink (input valid, r_low, r_high, output ready);
endinterface

interface malu_cfg_if;
	import malu_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/malu_dp.sv -----
// Datapath of the modular ALU: operand registers and one shared add/subtract unit.
// Depends on malu_pkg; driven one operation per cycle by malu_ctrl.
module malu_dp #(
	parameter int OPERAND_BITS = malu_pkg::OPERAND_BITS_DEF
) (
	input  logic                    clk,
	input  malu_pkg::dp_op_t        op,
	input  logic [OPERAND_BITS-1:0] a_in,
	input  logic [OPERAND_BITS-1:0] b_in,
	input  logic [OPERAND_BITS-1:0] p,
	output malu_pkg::dp_stat_t      stat,
	output logic [OPERAND_BITS-1:0] res
);
	import malu_pkg::*;

	localparam int W  = OPERAND_BITS;
	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] CNT_TOP = CW'(W - 1);

	logic [W-1:0]  c_q, mx_q, my_q, sq_q, acc_q, e_q;
	logic [CW-1:0] cnt_q;
	logic          flag_q;  // carry of add / borrow of subtract

	logic [W-1:0] dbl;
	logic [W-1:0] add_x, add_y;
	logic         add_sub;
	logic [W:0]   sum;
	logic [W-1:0] sum_w;
	logic         sum_top;  // carry out; on subtract, set when x >= y

	assign dbl = {c_q[W-2:0], 1'b0};

	// operand selection for the shared adder
	always_comb begin
		add_x   = c_q;
		add_y   = p;
		add_sub = 1'b1;
		unique case (op)
			DP_ADD_AB: begin
				add_x   = mx_q;
				add_y   = my_q;
				add_sub = 1'b0;
			end
			DP_SUB_AB: begin
				add_x = mx_q;
				add_y = my_q;
			end
			DP_FIX_BORROW: add_sub = 1'b0;
			DP_MUL_DBL:    add_x = dbl;
			DP_MUL_ADD: begin
				add_y   = my_q;
				add_sub = 1'b0;
			end
			default: ;
		endcase
	end

	assign sum     = {1'b0, add_x} + {1'b0, add_y ^ {W{add_sub}}} + (W + 1)'(add_sub);
	assign sum_w   = sum[W-1:0];
	assign sum_top = sum[W];

	// register updates
	always_ff @(posedge clk) begin
		unique case (op)
			DP_LOAD: begin
				mx_q  <= a_in;
				my_q  <= b_in;
				sq_q  <= a_in;
				e_q   <= b_in;
				c_q   <= '0;
				cnt_q <= CNT_TOP;
			end
			DP_ADD_AB: begin
				c_q    <= sum_w;
				flag_q <= sum_top;
			end
			DP_RED_CARRY: if (flag_q || sum_top) begin
				c_q <= sum_w;
			end
			DP_SUB_AB: begin
				c_q    <= sum_w;
				flag_q <= !sum_top;
			end
			DP_FIX_BORROW: if (flag_q) begin
				c_q <= sum_w;
			end
			DP_MUL_DBL: c_q <= sum_top ? sum_w : dbl;
			DP_MUL_ADD: c_q <= sum_w;
			DP_MUL_RED: begin
				if (sum_top) begin
					c_q <= sum_w;
				end
				mx_q  <= {mx_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			DP_MUL_INIT_SQ: begin
				mx_q  <= sq_q;
				my_q  <= sq_q;
				c_q   <= '0;
				cnt_q <= CNT_TOP;
			end
			DP_MUL_INIT_ACC: begin
				mx_q  <= acc_q;
				my_q  <= sq_q;
				c_q   <= '0;
				cnt_q <= CNT_TOP;
			end
			DP_SQ_FROM_C: sq_q <= c_q;
			DP_SQ_FROM_C_SHR: begin
				sq_q <= c_q;
				e_q  <= e_q >> 1;
			end
			DP_ACC_FROM_SQ_SHR: begin
				acc_q <= sq_q;
				e_q   <= e_q >> 1;
			end
			DP_ACC_FROM_C: acc_q <= c_q;
			DP_E_SHR:      e_q <= e_q >> 1;
			DP_ONE:        c_q <= W'(1);
			DP_C_FROM_ACC: c_q <= acc_q;
			default: ;
		endcase
	end

	// status back to the controller
	assign stat.mul_bit  = mx_q[W-1];
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.e_zero   = (e_q == '0);
	assign stat.e_lsb    = e_q[0];

	assign res = c_q;

endmodule

// ----- hw/rtl/malu_ctrl.sv -----
// Controller of the modular ALU: sequences add, subtract, multiply and power.
// Depends on malu_pkg; issues one datapath operation per cycle to malu_dp.
module malu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  malu_pkg::cmd_t     cmd,
	output logic               in_ready,
	input  malu_pkg::dp_stat_t stat,
	output malu_pkg::dp_op_t   op,
	input  logic               out_free,
	output logic               res_load
);
	import malu_pkg::*;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_DONE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		op       = DP_NOP;
		in_ready = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op    = DP_LOAD;
					ret_d = RET_DONE;
					unique case (cmd)
						CMD_ADD: state_d = ST_ADD_SUM;
						CMD_SUB: state_d = ST_SUB_DIF;
						CMD_MUL: state_d = ST_MUL_DBL;
						CMD_POW: state_d = ST_PW_START;
					endcase
				end
			end
			ST_ADD_SUM: begin
				op      = DP_ADD_AB;
				state_d = ST_ADD_RED;
			end
			ST_ADD_RED: begin
				op      = DP_RED_CARRY;
				state_d = ST_DONE;
			end
			ST_SUB_DIF: begin
				op      = DP_SUB_AB;
				state_d = ST_SUB_FIX;
			end
			ST_SUB_FIX: begin
				op      = DP_FIX_BORROW;
				state_d = ST_DONE;
			end
			// interleaved multiply: double+reduce, optional add, reduce
			ST_MUL_DBL: begin
				op      = DP_MUL_DBL;
				state_d = stat.mul_bit ? ST_MUL_ADD : ST_MUL_RED;
			end
			ST_MUL_ADD: begin
				op      = DP_MUL_ADD;
				state_d = ST_MUL_RED;
			end
			ST_MUL_RED: begin
				op = DP_MUL_RED;
				if (!stat.cnt_zero) begin
					state_d = ST_MUL_DBL;
				end else begin
					unique case (ret_q)
						RET_DONE: state_d = ST_DONE;
						RET_SQ1:  state_d = ST_PW_SQ1_END;
						RET_SQ2:  state_d = ST_PW_SQ2_END;
						RET_ACC:  state_d = ST_PW_ACC_END;
					endcase
				end
			end
			// power: return 1 for a zero exponent, else strip trailing zero exponent bits by squaring
			ST_PW_START: begin
				if (stat.e_zero) begin
					op      = DP_ONE;
					state_d = ST_DONE;
				end else if (!stat.e_lsb) begin
					op      = DP_MUL_INIT_SQ;
					ret_d   = RET_SQ1;
					state_d = ST_MUL_DBL;
				end else begin
					op      = DP_ACC_FROM_SQ_SHR;
					state_d = ST_PW_LOOP;
				end
			end
			ST_PW_SQ1_END: begin
				op      = DP_SQ_FROM_C_SHR;
				state_d = ST_PW_START;
			end
			// main square-and-multiply loop
			ST_PW_LOOP: begin
				if (stat.e_zero) begin
					op      = DP_C_FROM_ACC;
					state_d = ST_DONE;
				end else begin
					op      = DP_MUL_INIT_SQ;
					ret_d   = RET_SQ2;
					state_d = ST_MUL_DBL;
				end
			end
			ST_PW_SQ2_END: begin
				op      = DP_SQ_FROM_C;
				state_d = stat.e_lsb ? ST_PW_ACC_INIT : ST_PW_SHIFT;
			end
			ST_PW_ACC_INIT: begin
				op      = DP_MUL_INIT_ACC;
				ret_d   = RET_ACC;
				state_d = ST_MUL_DBL;
			end
			ST_PW_ACC_END: begin
				op      = DP_ACC_FROM_C;
				state_d = ST_PW_SHIFT;
			end
			ST_PW_SHIFT: begin
				op      = DP_E_SHR;
				state_d = ST_PW_LOOP;
			end
			// hand the result to the output register once it is free
			ST_DONE: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/modular_alu_96bit_top.sv -----
// Top level of the modular ALU: channels, modulus registers, output register.
// Depends on malu_pkg, the channel interfaces, malu_ctrl, malu_dp and the assertion header.
//
// Modular add, subtract, multiply and power over a configured odd modulus
// P = {prime_high, prime_low} below 2^95, in OPERAND_BITS-wide arithmetic.
// One item is worked on at a time; the result sits in an output register, so
// the next request beat is taken while an earlier result waits. All work runs
// through one shared add/subtract unit, one operation per cycle: add and
// subtract each take a sum or difference step and then a correction step by P;
// a multiply steps through all W = OPERAND_BITS multiplier bits, each with a
// doubling, an add when the bit is set, and a reduction; a power does one
// squaring per exponent bit below its top set bit plus one multiply per further
// set bit, at most 2W-2 multiplies. Exponent zero returns 1.
// Config writes are taken at any time and must only be made while idle.
`include "modular_alu_96bit_top_assert.svh"

module modular_alu_96bit_top #(
	parameter int OPERAND_BITS = malu_pkg::OPERAND_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	malu_req_if.sink   req,
	malu_rsp_if.source rsp,
	malu_cfg_if.sink   cfg
);
	import malu_pkg::*;

	localparam int W = OPERAND_BITS;

	logic [LOW_BITS-1:0]        prime_low_q;
	logic [PRIME_HIGH_BITS-1:0] prime_high_q;

	logic [FIELD_BITS-1:0] a_wide, b_wide, p_wide, res_wide;
	logic [W-1:0]          a_w, b_w, p_w, res_w;

	dp_op_t   op;
	dp_stat_t stat;
	logic     out_free;
	logic     res_load;
	logic     in_ready;

	logic                out_valid_q;
	logic [RES_BITS-1:0] r_q;

	// modulus registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_low_q  <= LOW_BITS'(1);
			prime_high_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_PRIME_LOW) begin
				prime_low_q <= cfg.data;
			end else if (cfg.index == CFG_PRIME_HIGH) begin
				prime_high_q <= cfg.data[PRIME_HIGH_BITS-1:0];
			end
		end
	end

	// width conversion between fields and operand width
	assign a_wide = FIELD_BITS'({req.a_high, req.a_low});
	assign b_wide = FIELD_BITS'({req.b_high, req.b_low});
	assign p_wide = FIELD_BITS'({prime_high_q, prime_low_q});
	assign a_w    = a_wide[W-1:0];
	assign b_w    = b_wide[W-1:0];
	assign p_w    = p_wide[W-1:0];

	always_comb begin
		res_wide        = '0;
		res_wide[W-1:0] = res_w;
	end

	assign req.ready = in_ready;

	malu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.cmd      (cmd_t'(req.cmd)),
		.in_ready (in_ready),
		.stat     (stat),
		.op       (op),
		.out_free (out_free),
		.res_load (res_load)
	);

	malu_dp #(
		.OPERAND_BITS (OPERAND_BITS)
	) u_dp (
		.clk  (clk),
		.op   (op),
		.a_in (a_w),
		.b_in (b_w),
		.p    (p_w),
		.stat (stat),
		.res  (res_w)
	);

	// output register
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			r_q <= res_wide[RES_BITS-1:0];
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.r_low  = r_q[LOW_BITS-1:0];
	assign rsp.r_high = r_q[RES_BITS-1:LOW_BITS];

	// checks
	`MALU_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "request taken while busy")
	`MALU_ASSERT_NEXT(a_result_shown, res_load, rsp.valid, "loaded result not presented")
	`MALU_ASSERT_SAME(a_no_overwrite, rsp.valid && !rsp.ready, !res_load, "pending result overwritten")

endmodule
